// ----- rtl/core/utf8u16_pkg.sv -----
// utf8u16_pkg: types, constants and small helper functions shared by the
// utf-8 to utf-16 decoder core, its decode logic and its output buffer.
// no dependencies.
package utf8u16_pkg;

  localparam logic [15:0] REPL_UNIT  = 16'hFFFD;
  localparam logic [5:0]  HI_SURR_HI = 6'b110110;
  localparam logic [5:0]  LO_SURR_HI = 6'b110111;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // output buffer depth: one unit in flight plus a full two-unit item
  localparam int unsigned OBUF_DEPTH = 3;
  localparam int unsigned OBUF_PTR_W = 2;

  // decoder state
  typedef struct packed {
    logic [30:0] pv;       // bits gathered so far
    logic [2:0]  rem;      // continuation bytes still awaited
    logic [2:0]  seq_len;  // length of the open sequence
    logic        skip;     // drop continuation bytes
  } state_t;

  // up to two code units caused by one item
  typedef struct packed {
    logic [1:0]  n;
    logic [15:0] unit0;
    logic        rep0;
    logic [15:0] unit1;
    logic        rep1;
  } results_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        rep;
    logic        last;
  } entry_t;

  // smallest value that a sequence of the given length may encode
  function automatic logic [30:0] min_value(input logic [2:0] len);
    logic [30:0] lim;
    unique case (len)
      3'd2:    lim = 31'h0000080;
      3'd3:    lim = 31'h0000800;
      3'd4:    lim = 31'h0010000;
      3'd5:    lim = 31'h0200000;
      3'd6:    lim = 31'h4000000;
      default: lim = 31'h0000000;
    endcase
    return lim;
  endfunction

  // false for surrogates, noncharacters and values above the unicode range
  function automatic logic value_allowed(input logic [30:0] wc);
    logic ok;
    ok = 1'b1;
    if (wc >= 31'h0110000) ok = 1'b0;
    if (wc[30:11] == 20'h0001B) ok = 1'b0;
    if (wc >= 31'h000FDD0 && wc <= 31'h000FDEF) ok = 1'b0;
    if (wc[15:1] == 15'h7FFF) ok = 1'b0;
    return ok;
  endfunction

  // pointer step modulo the buffer depth
  function automatic logic [OBUF_PTR_W-1:0] ptr_inc(input logic [OBUF_PTR_W-1:0] p);
    logic [OBUF_PTR_W-1:0] r;
    if (p == OBUF_PTR_W'(OBUF_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

endpackage

// ----- rtl/core/utf8u16_dec.sv -----
// utf8u16_dec: combinational decode of one utf-8 byte against the current
// state; gives the next state and up to two utf-16 code units.
// depends on utf8u16_pkg.
module utf8u16_dec (
  input  logic [7:0]            byte_i,
  input  logic                  end_i,
  input  utf8u16_pkg::state_t   st_i,
  output utf8u16_pkg::state_t   st_o,
  output utf8u16_pkg::results_t res_o
);
  import utf8u16_pkg::*;

  logic        cont;
  // fresh byte handling
  logic        f_emit;
  logic [15:0] f_unit;
  logic        f_rep;
  logic        f_skip;
  logic        f_open;
  logic [2:0]  f_len;
  logic [4:0]  f_bits;
  // continuation path
  logic [30:0] shifted;
  logic [2:0]  rem_dec;
  logic        overlong;
  logic        allowed;
  logic [20:0] supp;
  // candidate units
  logic        c_cut;
  logic        c_end;
  logic [1:0]  m_n;
  logic [15:0] m_u0;
  logic        m_r0;
  logic [15:0] m_u1;
  logic        m_r1;
  logic        use_fresh;
  state_t      nxt;

  assign cont = (byte_i[7:6] == 2'b10);

  always_comb begin
    f_emit = 1'b0;
    f_unit = {8'h00, byte_i};
    f_rep  = 1'b0;
    f_skip = 1'b0;
    f_open = 1'b0;
    f_len  = 3'd0;
    f_bits = 5'd0;
    if (!byte_i[7]) begin
      f_emit = (byte_i != 8'h00);
    end else if (!byte_i[6] || byte_i[7:1] == 7'h7F) begin
      // lone continuation or 0xfe/0xff lead
      f_emit = 1'b1;
      f_unit = REPL_UNIT;
      f_rep  = 1'b1;
      f_skip = 1'b1;
    end else begin
      f_open = 1'b1;
      if (!byte_i[5]) begin
        f_len  = 3'd2;
        f_bits = byte_i[4:0];
      end else if (!byte_i[4]) begin
        f_len  = 3'd3;
        f_bits = {1'b0, byte_i[3:0]};
      end else if (!byte_i[3]) begin
        f_len  = 3'd4;
        f_bits = {2'b00, byte_i[2:0]};
      end else if (!byte_i[2]) begin
        f_len  = 3'd5;
        f_bits = {3'b000, byte_i[1:0]};
      end else begin
        f_len  = 3'd6;
        f_bits = {4'b0000, byte_i[0]};
      end
    end
  end

  assign shifted  = {st_i.pv[24:0], byte_i[5:0]};
  assign rem_dec  = st_i.rem - 3'd1;
  assign overlong = (shifted < min_value(st_i.seq_len));
  assign allowed  = value_allowed(shifted);
  assign supp     = shifted[20:0] - SUPP_BASE;

  always_comb begin
    nxt       = st_i;
    c_cut     = 1'b0;
    c_end     = 1'b0;
    m_n       = 2'd0;
    m_u0      = REPL_UNIT;
    m_r0      = 1'b1;
    m_u1      = REPL_UNIT;
    m_r1      = 1'b1;
    use_fresh = 1'b0;

    if (st_i.rem != 3'd0) begin
      if (cont) begin
        nxt.pv  = shifted;
        nxt.rem = rem_dec;
        if (rem_dec == 3'd0) begin
          nxt.seq_len = 3'd0;
          nxt.pv      = '0;
          m_n         = 2'd1;
          if (overlong) begin
            nxt.skip = 1'b1;
          end else if (allowed) begin
            if (shifted[30:16] == 15'd0) begin
              m_u0 = shifted[15:0];
              m_r0 = 1'b0;
            end else begin
              // surrogate pair
              m_n  = 2'd2;
              m_u0 = {HI_SURR_HI, supp[19:10]};
              m_r0 = 1'b0;
              m_u1 = {LO_SURR_HI, supp[9:0]};
              m_r1 = 1'b0;
            end
          end
        end
      end else begin
        // sequence cut short, then the byte is taken afresh
        c_cut     = 1'b1;
        use_fresh = 1'b1;
      end
    end else if (!(st_i.skip && cont)) begin
      use_fresh = 1'b1;
    end

    if (use_fresh) begin
      nxt.skip = f_skip;
      if (f_open) begin
        nxt.pv      = {26'd0, f_bits};
        nxt.seq_len = f_len;
        nxt.rem     = f_len - 3'd1;
      end else begin
        nxt.pv      = '0;
        nxt.seq_len = 3'd0;
        nxt.rem     = 3'd0;
      end
      if (f_emit) begin
        m_n  = 2'd1;
        m_u0 = f_unit;
        m_r0 = f_rep;
      end
    end

    // string ends inside an open sequence
    if (end_i && nxt.rem != 3'd0) c_end = 1'b1;
    if (end_i || byte_i == 8'h00) nxt = '0;
  end

  assign st_o = nxt;

  always_comb begin
    res_o       = '0;
    res_o.unit0 = REPL_UNIT;
    res_o.rep0  = 1'b1;
    res_o.unit1 = REPL_UNIT;
    res_o.rep1  = 1'b1;
    if (c_cut) begin
      res_o.n = 2'd1;
      if (m_n != 2'd0) begin
        res_o.n     = 2'd2;
        res_o.unit1 = m_u0;
        res_o.rep1  = m_r0;
      end else if (c_end) begin
        res_o.n = 2'd2;
      end
    end else if (m_n != 2'd0) begin
      res_o.n     = 2'd1;
      res_o.unit0 = m_u0;
      res_o.rep0  = m_r0;
      if (m_n == 2'd2) begin
        res_o.n     = 2'd2;
        res_o.unit1 = m_u1;
        res_o.rep1  = m_r1;
      end else if (c_end) begin
        res_o.n = 2'd2;
      end
    end else if (c_end) begin
      res_o.n = 2'd1;
    end
  end

endmodule

// ----- rtl/core/utf8u16_obuf.sv -----
// utf8u16_obuf: three-entry result buffer; takes up to two units per cycle while
// room_o is high and hands out one unit per cycle on a valid/ready channel.
// depends on utf8u16_pkg.
module utf8u16_obuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  utf8u16_pkg::results_t res_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output utf8u16_pkg::entry_t   out_o
);
  import utf8u16_pkg::*;

  entry_t                mem_q [OBUF_DEPTH];
  logic [OBUF_PTR_W-1:0] wr_q, wr_d;
  logic [OBUF_PTR_W-1:0] rd_q, rd_d;
  logic [1:0]            count_q, count_d;
  logic [1:0]            push_n;
  logic                  pop;
  entry_t                e0, e1;

  assign push_n      = push_i ? res_i.n : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign room_o      = (count_q <= 2'd1);
  assign out_o       = mem_q[rd_q];

  assign e0 = '{unit: res_i.unit0, rep: res_i.rep0, last: (res_i.n == 2'd1)};
  assign e1 = '{unit: res_i.unit1, rep: res_i.rep1, last: 1'b1};

  always_comb begin
    wr_d = wr_q;
    if (push_n == 2'd1) wr_d = ptr_inc(wr_q);
    else if (push_n == 2'd2) wr_d = ptr_inc(ptr_inc(wr_q));
    rd_d    = pop ? ptr_inc(rd_q) : rd_q;
    count_d = count_q - {1'b0, pop} + push_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) mem_q[wr_q] <= e0;
    if (push_n == 2'd2) mem_q[ptr_inc(wr_q)] <= e1;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n == 2'd2 |-> count_q - {1'b0, pop} <= 2'd1)
    else $error("result buffer overflow");
`endif

endmodule

// ----- rtl/core/utf8_to_utf16_decoder_core.sv -----
// utf8_to_utf16_decoder_core: top level of the utf-8 to utf-16 decoder.
// depends on utf8u16_pkg, utf8u16_dec and utf8u16_obuf.
//
// input channel: one utf-8 byte per item (byte_in_i, string_end_i) on
// in_valid_i / in_ready_o. a zero byte or a byte with string_end_i set ends
// the string and returns the decoder to its reset state.
// output channel: one utf-16 code unit per item (code_unit_o, replaced_o,
// run_last_o) on out_valid_o / out_ready_i. a byte gives zero, one or two
// units; run_last_o marks the last unit caused by a byte.
// buffering: the units of a byte are registered in the result buffer as the byte is taken.
// throughput: one byte per cycle while each byte gives at most one unit and
// out_ready_i stays high; a surrogate pair or two replacement units leave
// one at a time by the single output port of the three-entry result buffer.
// reset: decoder state and buffer are cleared, no output item is pending.
// stall: the buffer takes bytes while it holds at most one unit, then in_ready_o
// drops until the receiver takes units again.
module utf8_to_utf16_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        replaced_o,
  output logic        run_last_o
);
  import utf8u16_pkg::*;

  state_t   st_q, st_d;
  results_t res;
  entry_t   head;
  logic     accept;

  assign accept = in_valid_i && in_ready_o;

  utf8u16_dec u_dec (
    .byte_i (byte_in_i),
    .end_i  (string_end_i),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  utf8u16_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (res),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  assign code_unit_o = head.unit;
  assign replaced_o  = head.rep;
  assign run_last_o  = head.last;

`ifndef SYNTH
  a_no_skip_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.rem != 3'd0 |-> !st_q.skip)
    else $error("skip flag set inside an open sequence");

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.rem != 3'd0 |-> st_q.seq_len > st_q.rem)
    else $error("continuation count not below sequence length");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (string_end_i || byte_in_i == 8'h00) |=>
      st_q.rem == 3'd0 && st_q.seq_len == 3'd0 && !st_q.skip)
    else $error("state not cleared at end of string");

  a_full_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with nothing to deliver");
`endif

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for utf8_to_utf16_decoder_core.
// a byte-level decoder model predicts the utf-16 units, checked in order.
// depends on utf8u16_pkg and the decoder core rtl.
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_BYTES     = 1500;
  localparam int HOLD_CYCLES    = 250;
  localparam int MAX_REPORTS    = 10;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  byte_in    = 8'h00;
  logic        string_end = 1'b0;
  logic        out_ready  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [15:0] code_unit_o;
  logic        replaced_o;
  logic        run_last_o;

  utf8_to_utf16_decoder_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .byte_in_i    (byte_in),
    .string_end_i (string_end),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .code_unit_o  (code_unit_o),
    .replaced_o   (replaced_o),
    .run_last_o   (run_last_o)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // decoder model state
  logic [30:0] cp_acc;
  logic [2:0]  cont_left;
  logic [2:0]  seq_len;
  logic        skip_cont;
  logic [15:0] step_unit [2];
  logic        step_rep [2];
  int          step_n;

  utf8u16_pkg::entry_t pending_units[$];
  logic [7:0]          tx_bytes[$];

  int n_errors      = 0;
  int idle_cycles   = 0;
  int burst_left    = 0;
  int tx_gap_max    = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int rx_mode_left  = 0;
  int rx_phase      = 0;
  rx_mode_e rx_mode = RX_ALWAYS;

  function automatic bit unit_allowed(input logic [30:0] wc);
    if (wc >= 31'h0110000) return 1'b0;
    if ((wc & 31'h7FFFF800) == 31'h000D800) return 1'b0;
    if (wc >= 31'h000FDD0 && wc <= 31'h000FDEF) return 1'b0;
    if (wc[15:1] == 15'h7FFF) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void emit_unit(input logic [15:0] u, input logic rep);
    if (step_n < 2) begin
      step_unit[step_n] = u;
      step_rep[step_n]  = rep;
      step_n++;
    end
  endfunction

  function automatic void clear_decoder();
    cp_acc    = '0;
    cont_left = '0;
    seq_len   = '0;
    skip_cont = 1'b0;
  endfunction

  function automatic void open_fresh(input logic [7:0] b);
    skip_cont = 1'b0;
    if (b < 8'h80) begin
      if (b != 8'h00) emit_unit({8'h00, b}, 1'b0);
    end else if (b < 8'hC0 || b >= 8'hFE) begin
      emit_unit(utf8u16_pkg::REPL_UNIT, 1'b1);
      skip_cont = 1'b1;
    end else begin
      if (b < 8'hE0) begin
        seq_len = 3'd2;
        cp_acc  = 31'(b[4:0]);
      end else if (b < 8'hF0) begin
        seq_len = 3'd3;
        cp_acc  = 31'(b[3:0]);
      end else if (b < 8'hF8) begin
        seq_len = 3'd4;
        cp_acc  = 31'(b[2:0]);
      end else if (b < 8'hFC) begin
        seq_len = 3'd5;
        cp_acc  = 31'(b[1:0]);
      end else begin
        seq_len = 3'd6;
        cp_acc  = 31'(b[0]);
      end
      cont_left = seq_len - 3'd1;
    end
  endfunction

  function automatic void close_sequence();
    logic [30:0] wc;
    logic [30:0] floor_v;
    logic [30:0] v;
    wc = cp_acc;
    case (seq_len)
      3'd2:    floor_v = 31'h0000080;
      3'd3:    floor_v = 31'h0000800;
      3'd4:    floor_v = 31'h0010000;
      3'd5:    floor_v = 31'h0200000;
      3'd6:    floor_v = 31'h4000000;
      default: floor_v = 31'h0000000;
    endcase
    seq_len = '0;
    cp_acc  = '0;
    if (wc < floor_v) begin
      // overlong: replace and drop the continuation bytes that follow
      emit_unit(utf8u16_pkg::REPL_UNIT, 1'b1);
      skip_cont = 1'b1;
    end else if (!unit_allowed(wc)) begin
      emit_unit(utf8u16_pkg::REPL_UNIT, 1'b1);
    end else if (wc < 31'h0010000) begin
      emit_unit(wc[15:0], 1'b0);
    end else begin
      v = wc - 31'h0010000;
      emit_unit(16'hD800 | {6'b0, v[19:10]}, 1'b0);
      emit_unit(16'hDC00 | {6'b0, v[9:0]}, 1'b0);
    end
  endfunction

  // work out the units one accepted byte causes and queue them
  function automatic void decode_byte(input logic [7:0] b, input logic e);
    logic is_cont;
    utf8u16_pkg::entry_t r;
    is_cont = (b[7:6] == 2'b10);
    step_n  = 0;
    if (cont_left != 0) begin
      if (is_cont) begin
        cp_acc    = {cp_acc[24:0], b[5:0]};
        cont_left = cont_left - 3'd1;
        if (cont_left == 0) close_sequence();
      end else begin
        // cut sequence, then the byte starts over
        emit_unit(utf8u16_pkg::REPL_UNIT, 1'b1);
        cont_left = '0;
        seq_len   = '0;
        cp_acc    = '0;
        open_fresh(b);
      end
    end else if (!(skip_cont && is_cont)) begin
      open_fresh(b);
    end
    if (e && cont_left != 0) emit_unit(utf8u16_pkg::REPL_UNIT, 1'b1);
    if (e || b == 8'h00) clear_decoder();
    for (int i = 0; i < step_n; i++) begin
      r.unit = step_unit[i];
      r.rep  = step_rep[i];
      r.last = (i == step_n - 1);
      pending_units.push_back(r);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    in_valid   <= 1'b1;
    byte_in    <= b;
    string_end <= e;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    decode_byte(b, e);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = $urandom_range(0, tx_gap_max);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // up to four bytes, most significant first
  task automatic send_bytes(input int n, input logic [31:0] data, input logic e_last);
    for (int i = 0; i < n; i++) send_byte(data[8*(n-1-i) +: 8], e_last && (i == n - 1));
  endtask

  task automatic send_tx_bytes(input logic e_last);
    for (int i = 0; i < tx_bytes.size(); i++)
      send_byte(tx_bytes[i], e_last && (i == tx_bytes.size() - 1));
  endtask

  // sender holds off until every expected unit has come out
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_units.size() != 0);
  endtask

  function automatic int natural_len(input logic [30:0] cp);
    if (cp < 31'h80) return 1;
    if (cp < 31'h800) return 2;
    if (cp < 31'h10000) return 3;
    if (cp < 31'h200000) return 4;
    if (cp < 31'h4000000) return 5;
    return 6;
  endfunction

  function automatic void push_enc(input logic [30:0] cp, input int len);
    logic [7:0]  pfx;
    logic [7:0]  mask;
    logic [30:0] tmp;
    if (len == 1) begin
      tx_bytes.push_back({1'b0, cp[6:0]});
      return;
    end
    case (len)
      2:       begin pfx = 8'hC0; mask = 8'h1F; end
      3:       begin pfx = 8'hE0; mask = 8'h0F; end
      4:       begin pfx = 8'hF0; mask = 8'h07; end
      5:       begin pfx = 8'hF8; mask = 8'h03; end
      default: begin pfx = 8'hFC; mask = 8'h01; end
    endcase
    tmp = cp >> (6 * (len - 1));
    tx_bytes.push_back(pfx | (tmp[7:0] & mask));
    for (int i = len - 2; i >= 0; i--) begin
      tmp = cp >> (6 * i);
      tx_bytes.push_back(8'h80 | {2'b00, tmp[5:0]});
    end
  endfunction

  function automatic logic [30:0] pick_special();
    case ($urandom_range(0, 6))
      0:       return 31'($urandom_range(32'hD800, 32'hDFFF));
      1:       return 31'($urandom_range(32'hFDD0, 32'hFDEF));
      2:       return 31'(($urandom_range(0, 16) << 16) | 32'hFFFE | $urandom_range(0, 1));
      3:       return 31'h10FFFF;
      4:       return 31'($urandom_range(32'h110000, 32'h1FFFFF));
      5:       return 31'hFFFD;
      default: return $urandom_range(0, 1) ? 31'hFDCF : 31'hFDF0;
    endcase
  endfunction

  // one character's bytes: mostly well formed, some broken, some noise
  function automatic void gen_char();
    int          cls;
    int          len;
    logic [30:0] cp;
    cls = $urandom_range(0, 99);
    if (cls < 25) begin
      push_enc(31'($urandom_range(1, 127)), 1);
    end else if (cls < 40) begin
      push_enc(31'($urandom_range(32'h80, 32'h7FF)), 2);
    end else if (cls < 55) begin
      push_enc(31'($urandom_range(32'h800, 32'hFFFF)), 3);
    end else if (cls < 65) begin
      push_enc(31'($urandom_range(32'h10000, 32'h10FFFF)), 4);
    end else if (cls < 72) begin
      cp = pick_special();
      push_enc(cp, natural_len(cp));
    end else if (cls < 77) begin
      if ($urandom_range(0, 1)) push_enc(31'($urandom_range(32'h200000, 32'h3FFFFFF)), 5);
      else push_enc(31'($urandom_range(32'h4000000, 32'h7FFFFFFF)), 6);
    end else if (cls < 83) begin
      cp = 31'($urandom_range(0, 32'hFFFF));
      push_enc(cp, $urandom_range(natural_len(cp) + 1, 6));
    end else if (cls < 90) begin
      cp  = 31'($urandom_range(32'h80, 32'h10FFFF));
      len = natural_len(cp);
      push_enc(cp, len);
      repeat ($urandom_range(1, len - 1)) void'(tx_bytes.pop_back());
    end else if (cls < 94) begin
      repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end else if (cls < 96) begin
      tx_bytes.push_back(8'hFE | 8'($urandom_range(0, 1)));
    end else begin
      tx_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic test_well_formed();
    tx_gap_max = 3;
    send_bytes(1, 32'h00, 1'b0);
    send_bytes(1, 32'h7F, 1'b0);
    send_bytes(2, 32'hC3A9, 1'b0);
    send_bytes(3, 32'hEFBFBD, 1'b0);     // literal u+fffd, not a replacement
    send_bytes(4, 32'hF09F9880, 1'b1);   // surrogate pair
  endtask

  task automatic test_malformed();
    send_bytes(2, 32'h8080, 1'b0);       // lone continuation, then skipped
    send_bytes(1, 32'hFF, 1'b0);
    send_bytes(2, 32'hC080, 1'b0);       // overlong
    send_bytes(3, 32'hEDA080, 1'b0);     // surrogate value
    send_bytes(2, 32'hC3FE, 1'b0);       // cut by an invalid lead: two replacements
    send_bytes(2, 32'hE282, 1'b1);       // truncated at string end
    send_bytes(2, 32'hE200, 1'b0);       // cut by zero byte
    drain_outputs();
  endtask

  // receiver holds off while the sender keeps offering two-unit items
  task automatic test_backpressure();
    tx_gap_max = 0;
    burst_left = 1000;
    tx_bytes.delete();
    repeat (12) push_enc(31'($urandom_range(32'h10000, 32'h10FFFF)), 4);
    repeat (6) begin
      tx_bytes.push_back(8'hC3);
      tx_bytes.push_back(8'hFE);
    end
    hold_requests++;
    send_tx_bytes(1'b1);
    drain_outputs();
    burst_left = 0;
  endtask

  task automatic test_random_strings();
    int n_rand;
    int next_pause;
    int term;
    n_rand     = 0;
    next_pause = 400;
    while (n_rand < RAND_BYTES) begin
      if ($urandom_range(0, 7) == 0) tx_gap_max = $urandom_range(0, 6);
      tx_bytes.delete();
      repeat ($urandom_range(1, 8)) gen_char();
      term = $urandom_range(0, 9);
      if (term >= 5 && term < 8) tx_bytes.push_back(8'h00);
      send_tx_bytes(term < 5 || (term < 8 && $urandom_range(0, 1)));
      n_rand += tx_bytes.size();
      if (n_rand >= next_pause) begin
        drain_outputs();
        next_pause += 400;
      end
    end
  endtask

  // receiver: random modes, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 300);
    end else begin
      rx_mode_left--;
    end
    rx_phase = (rx_phase == 4) ? 0 : rx_phase + 1;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:   out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
        default:     out_ready <= (rx_phase < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    utf8u16_pkg::entry_t exp_u;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_units.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected unit %h rep %b last %b", code_unit_o, replaced_o, run_last_o);
      end else begin
        exp_u = pending_units.pop_front();
        if (code_unit_o !== exp_u.unit || replaced_o !== exp_u.rep ||
            run_last_o !== exp_u.last) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("mismatch: expected unit %h rep %b last %b, got unit %h rep %b last %b",
                     exp_u.unit, exp_u.rep, exp_u.last, code_unit_o, replaced_o, run_last_o);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d units outstanding",
               idle_cycles, pending_units.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    clear_decoder();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_well_formed();
    test_malformed();
    test_backpressure();
    test_random_strings();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_units.size() != 0);
    repeat (8) @(posedge clk);
    if (n_errors == 0 && pending_units.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- utf8_to_utf16_decoder_core.f -----
rtl/core/utf8u16_pkg.sv
rtl/core/utf8u16_dec.sv
rtl/core/utf8u16_obuf.sv
rtl/core/utf8_to_utf16_decoder_core.sv
dv/tb_top.sv
